// ===== sv/cdli_pkg.sv =====
`timescale 1ns / 1ps

package cdli_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSED_VIEW = 1'b1;

  typedef enum logic [1:0] {
    OP_SHIFT  = 2'd0,
    OP_READ   = 2'd1,
    OP_INTERP = 2'd2
  } opcode_e;

  typedef struct packed {
    logic latch;
    logic clr_wr;
    logic mod_step;
    logic sh_rd;
    logic sh_wr;
    logic rd_b;
    logic cap_a;
    logic mul;
    logic sum;
    logic rd_end;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       mod_last;
    logic       in_range;
    logic       out_free;
    logic [1:0] op;
  } status_t;

endpackage

// ===== sv/circular_delay_line_interp_core.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  opcode_i, new_sample_i, index_whole_i,
//                                              index_fraction_i
// out      output     out_valid_o / out_stall_i sample_out_o
// cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One transaction at a time. Shift: read, write, done. Indexed read: read A, end, done;
// interpolated read: read A, read B, multiply, sum, done. The bit-serial remainder steps
// run first when index_whole_i is not below the active length. The RAM read is
// registered, one address a cycle.
// After reset the store is cleared, one entry a cycle, with in_stall_o high.
// A finished result waits in the output register while the next transaction is taken.

module circular_delay_line_interp_core import cdli_pkg::*; #(
  parameter int MAX_DEPTH     = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [$clog2(MAX_DEPTH):0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic signed [SAMPLE_BITS-1:0]  new_sample_i,
  input  logic [$clog2(MAX_DEPTH)-1:0]   index_whole_i,
  input  logic [FRACTION_BITS-1:0]       index_fraction_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  sample_out_o
);

  cmd_t    cmd;
  status_t status;

  cdli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  cdli_datapath #(
    .MAX_DEPTH     (MAX_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .new_sample_i     (new_sample_i),
    .index_whole_i    (index_whole_i),
    .index_fraction_i (index_fraction_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_out_o     (sample_out_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a transaction is still in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("output register loaded over a held result");

  a_write_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_wr, cmd.sh_wr, cmd.latch}))
    else $error("conflicting store write and input latch");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> in_stall_o)
    else $error("input open during store clear");

endmodule

// ===== sv/cdli_ram.sv =====
`timescale 1ns / 1ps

module cdli_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cdli_datapath.sv =====
`timescale 1ns / 1ps

module cdli_datapath import cdli_pkg::*; #(
  parameter int MAX_DEPTH     = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [$clog2(MAX_DEPTH):0]     cfg_data_i,
  input  logic [1:0]                     opcode_i,
  input  logic signed [SAMPLE_BITS-1:0]  new_sample_i,
  input  logic [$clog2(MAX_DEPTH)-1:0]   index_whole_i,
  input  logic [FRACTION_BITS-1:0]       index_fraction_i,
  input  cmd_t                           cmd_i,
  output status_t                        status_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  sample_out_o
);

  localparam int AW = $clog2(MAX_DEPTH);
  localparam int LW = AW + 1;
  localparam int SB = SAMPLE_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int PW = SB + FB + 2;

  logic [LW-1:0]        len_q;
  logic                 rev_q;
  logic [AW-1:0]        ptr_q;
  logic [AW-1:0]        cnt_q;
  logic                 out_valid_q;

  logic [1:0]           op_q;
  logic signed [SB-1:0] sample_q;
  logic [FB-1:0]        frac_q;
  logic [AW-1:0]        div_q;
  logic [AW-1:0]        rem_q;
  logic signed [SB-1:0] a_q;
  logic signed [PW-1:0] prod_q;
  logic signed [SB-1:0] res_q;
  logic signed [SB-1:0] out_q;

  logic [LW-1:0]        len_eff;
  logic [AW-1:0]        ptr_nxt;
  logic [LW-1:0]        trial;
  logic [AW-1:0]        rem_d;
  logic [LW-1:0]        rem_inc;
  logic [AW-1:0]        idx_b;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [SB-1:0]        wdata;
  logic                 we;
  logic [SB-1:0]        rdata;
  logic signed [SB:0]   diff;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] idx,
                                            input logic [AW-1:0] ptr,
                                            input logic [LW-1:0] len,
                                            input logic          rev);
    logic [LW-1:0] s;
    begin
      if (rev) begin
        s = {1'b0, ptr} + len - {1'b0, idx};
      end else begin
        s = {1'b0, ptr} + {1'b0, idx} + LW'(1);
      end
      if (s >= len) begin
        s = s - len;
      end
      return s[AW-1:0];
    end
  endfunction

  always_comb begin
    if (cfg_data_i == '0) begin
      len_eff = LW'(1);
    end else if (cfg_data_i > LW'(MAX_DEPTH)) begin
      len_eff = LW'(MAX_DEPTH);
    end else begin
      len_eff = cfg_data_i;
    end
  end

  assign ptr_nxt = (({1'b0, ptr_q} + LW'(1)) == len_q) ? '0 : ptr_q + AW'(1);

  assign trial = {rem_q, div_q[AW-1]};
  assign rem_d = (trial >= len_q) ? AW'(trial - len_q) : trial[AW-1:0];

  assign rem_inc = {1'b0, rem_q} + LW'(1);
  always_comb begin
    if (frac_q == '0) begin
      idx_b = rem_q;
    end else if (rem_inc == len_q) begin
      idx_b = '0;
    end else begin
      idx_b = rem_inc[AW-1:0];
    end
  end

  always_comb begin
    if (cmd_i.sh_rd) begin
      raddr = ptr_nxt;
    end else if (cmd_i.rd_b) begin
      raddr = slot_of(idx_b, ptr_q, len_q, rev_q);
    end else begin
      raddr = slot_of(rem_q, ptr_q, len_q, rev_q);
    end
  end

  assign we    = cmd_i.clr_wr | cmd_i.sh_wr;
  assign waddr = cmd_i.clr_wr ? cnt_q : ptr_nxt;
  assign wdata = cmd_i.clr_wr ? '0 : sample_q;

  cdli_ram #(
    .Width (SB),
    .Depth (MAX_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign diff = $signed({rdata[SB-1], rdata}) - $signed({a_q[SB-1], a_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LW'(MAX_DEPTH);
      rev_q       <= 1'b0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_ACTIVE_LENGTH) begin
        len_q <= len_eff;
        ptr_q <= '0;
      end else if (cmd_i.sh_wr) begin
        ptr_q <= ptr_nxt;
      end
      if (cfg_we_i && cfg_idx_i == CFG_REVERSED_VIEW) begin
        rev_q <= cfg_data_i[0];
      end
      if (cmd_i.latch) begin
        cnt_q <= '0;
      end else if (cmd_i.clr_wr || cmd_i.mod_step) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= opcode_i;
      sample_q <= new_sample_i;
      frac_q   <= index_fraction_i;
      div_q    <= index_whole_i;
      rem_q    <= status_o.in_range ? index_whole_i : '0;
      res_q    <= '0;
    end
    if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      div_q <= div_q << 1;
    end
    if (cmd_i.cap_a) begin
      a_q <= rdata;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(diff) * PW'($signed({1'b0, frac_q}));
    end
    if (cmd_i.sum) begin
      res_q <= a_q + SB'(prod_q >>> FB);
    end
    if (cmd_i.rd_end || cmd_i.sh_wr) begin
      res_q <= rdata;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign status_o.clear_last = (cnt_q == AW'(MAX_DEPTH - 1));
  assign status_o.mod_last   = (cnt_q == AW'(AW - 1));
  assign status_o.in_range   = ({1'b0, index_whole_i} < len_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.op         = op_q;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

// ===== sv/cdli_ctrl.sv =====
`timescale 1ns / 1ps

module cdli_ctrl import cdli_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  input  status_t    status_i,
  output cmd_t       cmd_o,
  output logic       in_stall_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SH_RD,
    ST_SH_WR,
    ST_RD_A,
    ST_RD_B,
    ST_RD_END,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (opcode_i) inside
            OP_SHIFT: state_d = ST_SH_RD;
            OP_READ, OP_INTERP: state_d = status_i.in_range ? ST_RD_A : ST_MOD;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: begin
        state_d = (status_i.op == OP_READ) ? ST_RD_END : ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_b  = 1'b1;
        cmd_o.cap_a = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_DONE;
      end
      ST_RD_END: begin
        cmd_o.rd_end = 1'b1;
        state_d      = ST_DONE;
      end
      ST_SH_RD: begin
        cmd_o.sh_rd = 1'b1;
        state_d     = ST_SH_WR;
      end
      ST_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
